// ===== sv/svadd_pkg.sv =====
// ----------------------------------------------------------------------------
// svadd_pkg
// Shared types, constants and helpers for the sparse vector adder: payload
// structs, operation codes, controller states and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package svadd_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int INDEX_W      = 16;
  localparam int VALUE_W      = 32;
  localparam int ENTRY_W      = INDEX_W + VALUE_W;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_ADD   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                      mode;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]         index_res;
    logic signed [VALUE_W-1:0]  value_res;
    logic                       last;
    logic                       empty_res;
    logic                       overflow;
    logic                       order_error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_READ   = 2'd2,
    ST_EMPTY  = 2'd3
  } state_t;

  // Commands from the controller to the datapath; at most one is high.
  typedef struct packed {
    logic clear;
    logic load;
    logic add_direct;
    logic search_start;
    logic search_step;
    logic search_hit;
    logic search_miss;
    logic read_start;
    logic emit_entry;
    logic emit_empty;
  } svadd_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_last;
    logic read_last;
    logic first_zero;
    logic total_zero;
    logic out_free;
  } svadd_status_t;

  // Signed sum clamped to the Q16.16 range.
  function automatic logic signed [VALUE_W-1:0] sat_add(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    logic signed [VALUE_W:0] s;
    logic signed [VALUE_W-1:0] res;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      res = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      res = s[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/sparse_vector_add_top.sv =====
// ----------------------------------------------------------------------------
// sparse_vector_add_top
// Sparse vector adder in coordinate format: loads first-vector entries, adds
// second-vector entries by index search with saturation, and reads the table
// out in order.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_item_t  (mode, index, value)
//   out_     output     out_valid / out_ready out_item_t (index_res, value_res,
//                                             last, empty_res, overflow,
//                                             order_error)
//
// Clear and load complete as they are taken. An add compares up to
// min(first_count, CAPACITY) stored indices: the entry store's single read
// port gives one index comparison per cycle. A read-out emits the stored
// entries in order, or one empty result; out_ready stalls stretch it entry by
// entry. Reset empties the table at once; no clearing pass is needed. A result
// waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module sparse_vector_add_top import svadd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  svadd_cmd_t    cmd;
  svadd_status_t st;
  state_t        state;

  svadd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd),
    .state    (state)
  );

  svadd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Only one datapath operation may be commanded in a cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in one cycle");

  // A transfer of a clear leaves the table empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode == MODE_CLEAR) |=> st.total_zero)
    else $error("table not empty after clear");

  // Emitting the final entry returns the controller to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_entry && st.read_last) |=> (state == ST_IDLE))
    else $error("controller not idle after final read-out entry");

  // A result appears only after the controller asked for one.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit_entry || cmd.emit_empty))
    else $error("result raised without an emit command");

endmodule

// ===== sv/svadd_ram.sv =====
// ----------------------------------------------------------------------------
// svadd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module svadd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/svadd_ctrl.sv =====
// ----------------------------------------------------------------------------
// svadd_ctrl
// Controller: decodes accepted items and sequences the index search and the
// read-out over the entry store.
// ----------------------------------------------------------------------------
module svadd_ctrl import svadd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  mode_t         in_mode,
  output logic          in_ready,
  input  svadd_status_t st,
  output svadd_cmd_t    cmd,
  output state_t        state
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_ADD:  state_nxt = st.first_zero ? ST_IDLE : ST_SEARCH;
            MODE_READ: state_nxt = st.total_zero ? ST_EMPTY : ST_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (st.match || st.scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (st.out_free && st.read_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (st.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_CLEAR: cmd.clear = 1'b1;
            MODE_LOAD:  cmd.load  = 1'b1;
            MODE_ADD: begin
              cmd.add_direct   = st.first_zero;
              cmd.search_start = !st.first_zero;
            end
            MODE_READ:  cmd.read_start = !st.total_zero;
            default:    cmd = '0;
          endcase
        end
      end
      ST_SEARCH: begin
        // One stored first-vector index is compared each cycle.
        cmd.search_hit  = st.match;
        cmd.search_miss = !st.match && st.scan_last;
        cmd.search_step = !st.match && !st.scan_last;
      end
      ST_READ:  cmd.emit_entry = st.out_free;
      ST_EMPTY: cmd.emit_empty = st.out_free;
      default:  cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

// ===== sv/svadd_dp.sv =====
// ----------------------------------------------------------------------------
// svadd_dp
// Datapath: entry store, counts and flags, scan pointer, saturating adder and
// the output register.
// ----------------------------------------------------------------------------
module svadd_dp import svadd_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  in_item_t      in_data,
  input  svadd_cmd_t    cmd,
  output svadd_status_t st,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]              first_cnt_r, total_cnt_r;
  logic                       second_seen_r, ovf_r, ord_r;
  logic [AW-1:0]              scan_r;
  logic [INDEX_W-1:0]         hold_idx_r;
  logic signed [VALUE_W-1:0]  hold_val_r;
  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic                       full;
  logic [CW-1:0]              scan_inc;
  logic [AW-1:0]              rd_addr;
  logic [ENTRY_W-1:0]         rd_data;
  logic [INDEX_W-1:0]         rd_index;
  logic signed [VALUE_W-1:0]  rd_value;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ENTRY_W-1:0]         wr_data;
  logic                       want_append, append_ok, load_blocked;

  assign full      = (total_cnt_r == CW'(CAPACITY));
  assign scan_inc  = CW'(scan_r) + CW'(1);
  assign rd_index  = rd_data[ENTRY_W-1:VALUE_W];
  assign rd_value  = signed'(rd_data[VALUE_W-1:0]);

  assign st.match      = (rd_index == hold_idx_r);
  assign st.scan_last  = (scan_inc >= first_cnt_r);
  assign st.read_last  = (scan_inc == total_cnt_r);
  assign st.first_zero = (first_cnt_r == '0);
  assign st.total_zero = (total_cnt_r == '0);
  assign st.out_free   = !out_valid_r || out_ready;

  // The read address stays on the current entry while the output stalls.
  always_comb begin
    if (cmd.search_start || cmd.read_start) begin
      rd_addr = '0;
    end else if (cmd.search_step || cmd.emit_entry) begin
      rd_addr = scan_r + AW'(1);
    end else begin
      rd_addr = scan_r;
    end
  end

  assign load_blocked = cmd.load && second_seen_r;
  assign want_append  = (cmd.load && !second_seen_r) || cmd.add_direct || cmd.search_miss;
  assign append_ok    = want_append && !full;

  always_comb begin
    wr_en   = append_ok;
    wr_addr = total_cnt_r[AW-1:0];
    wr_data = {in_data.index, in_data.value};
    if (cmd.search_miss) begin
      wr_data = {hold_idx_r, hold_val_r};
    end
    if (cmd.search_hit) begin
      wr_en   = 1'b1;
      wr_addr = scan_r;
      wr_data = {hold_idx_r, sat_add(rd_value, hold_val_r)};
    end
  end

  svadd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r   <= '0;
      total_cnt_r   <= '0;
      second_seen_r <= 1'b0;
      ovf_r         <= 1'b0;
      ord_r         <= 1'b0;
      scan_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        first_cnt_r   <= '0;
        total_cnt_r   <= '0;
        second_seen_r <= 1'b0;
        ovf_r         <= 1'b0;
        ord_r         <= 1'b0;
      end
      if (load_blocked) begin
        ord_r <= 1'b1;
      end
      if (cmd.add_direct || cmd.search_start) begin
        second_seen_r <= 1'b1;
      end
      if (append_ok) begin
        total_cnt_r <= total_cnt_r + CW'(1);
        if (cmd.load) begin
          first_cnt_r <= first_cnt_r + CW'(1);
        end
      end
      if (want_append && full) begin
        ovf_r <= 1'b1;
      end
      scan_r <= rd_addr;
      if (cmd.emit_entry || cmd.emit_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      hold_idx_r <= in_data.index;
      hold_val_r <= in_data.value;
    end
    if (cmd.emit_entry) begin
      out_data_r.index_res   <= rd_index;
      out_data_r.value_res   <= rd_value;
      out_data_r.last        <= st.read_last;
      out_data_r.empty_res   <= 1'b0;
      out_data_r.overflow    <= ovf_r;
      out_data_r.order_error <= ord_r;
    end else if (cmd.emit_empty) begin
      out_data_r.index_res   <= '0;
      out_data_r.value_res   <= '0;
      out_data_r.last        <= 1'b1;
      out_data_r.empty_res   <= 1'b1;
      out_data_r.overflow    <= ovf_r;
      out_data_r.order_error <= ord_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse vector adder testbench
// Drives a short table of directed items followed by randomised episodes
// (clear, first-vector loads, second-vector adds, read-out) through the
// valid/ready input channel. An internal model of the entry table predicts
// the read-out entries not typed into the directed table, and each result
// transfer is checked field by field. Both channels idle at random, and
// the receiver's one long hold-off fills the block up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import svadd_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int ITEM_TARGET = 220;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 30;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    in_item_t  item;
    logic      has_res;
    out_item_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Model of the entry table.
  logic [INDEX_W-1:0]        tbl_index [CAP];
  logic signed [VALUE_W-1:0] tbl_value [CAP];
  int n_first;
  int n_total;
  bit b_seen;
  bit ovf_held;
  bit ord_held;

  out_item_t pending_entries [$];
  stim_row_t dir_rows [$];
  int  n_sent;
  int  n_fail;
  bit  sender_burst;

  sparse_vector_add_top #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t pack_item(mode_t m, logic [INDEX_W-1:0] idx,
                                         logic [VALUE_W-1:0] val);
    in_item_t it;
    it.mode  = m;
    it.index = idx;
    it.value = val;
    return it;
  endfunction

  function automatic out_item_t res_of(logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                                       logic lst, logic emp, logic ov, logic ord);
    out_item_t r;
    r.index_res   = idx;
    r.value_res   = val;
    r.last        = lst;
    r.empty_res   = emp;
    r.overflow    = ov;
    r.order_error = ord;
    return r;
  endfunction

  function automatic stim_row_t row(mode_t m, logic [INDEX_W-1:0] idx,
                                    logic [VALUE_W-1:0] val);
    stim_row_t s;
    s.item    = pack_item(m, idx, val);
    s.has_res = 1'b0;
    s.res     = '0;
    return s;
  endfunction

  function automatic stim_row_t row_res(mode_t m, logic [INDEX_W-1:0] idx,
                                        logic [VALUE_W-1:0] val, out_item_t r);
    stim_row_t s;
    s = row(m, idx, val);
    s.has_res = 1'b1;
    s.res     = r;
    return s;
  endfunction

  function automatic logic signed [VALUE_W-1:0] clamp_sum(logic signed [VALUE_W-1:0] a,
                                                         logic signed [VALUE_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[VALUE_W-1:0];
  endfunction

  function automatic void store_pair(logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] val);
    if (n_total >= CAP) begin
      ovf_held = 1'b1;
    end else begin
      tbl_index[n_total] = idx;
      tbl_value[n_total] = val;
      n_total++;
    end
  endfunction

  // Updates the table model for one accepted item and queues any read-out entries.
  function automatic void apply_to_table(in_item_t it);
    int k;
    bit hit;
    case (it.mode)
      MODE_CLEAR: begin
        n_first  = 0;
        n_total  = 0;
        b_seen   = 1'b0;
        ovf_held = 1'b0;
        ord_held = 1'b0;
      end
      MODE_LOAD: begin
        if (b_seen) begin
          ord_held = 1'b1;
        end else begin
          if (n_total < CAP) n_first++;
          store_pair(it.index, it.value);
        end
      end
      MODE_ADD: begin
        b_seen = 1'b1;
        hit    = 1'b0;
        // Only first-vector entries are searched, and only the first match is updated.
        for (k = 0; k < n_first; k++) begin
          if (!hit && tbl_index[k] == it.index) begin
            tbl_value[k] = clamp_sum(tbl_value[k], it.value);
            hit = 1'b1;
          end
        end
        if (!hit) store_pair(it.index, it.value);
      end
      default: begin
        if (n_total == 0) begin
          pending_entries.push_back(res_of('0, '0, 1'b1, 1'b1, ovf_held, ord_held));
        end else begin
          for (k = 0; k < n_total; k++) begin
            pending_entries.push_back(res_of(tbl_index[k], tbl_value[k], k == n_total - 1,
                                             1'b0, ovf_held, ord_held));
          end
        end
      end
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = 32'($urandom_range(0, 255)) - 32'd128;
      default: v = 32'($urandom);
    endcase
    return v;
  endfunction

  function automatic void check_field(string field, logic [31:0] exp_val,
                                      logic [31:0] act_val);
    if (exp_val !== act_val) begin
      n_fail++;
      $display("%0t: %s expected %h, got %h", $time, field, exp_val, act_val);
    end
  endfunction

  // Offers one item after a random gap and waits for its transfer.
  task automatic send_item(in_item_t it, logic has_res, out_item_t res);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    // Read-outs leave the table untouched, so a typed-in result replaces the prediction.
    if (has_res) pending_entries.push_back(res);
    else apply_to_table(it);
  endtask

  task automatic send_plain(mode_t m, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
    send_item(pack_item(m, idx, val), 1'b0, '0);
  endtask

  // Stimulus.
  initial begin
    int k;
    int n_a;
    int n_b;
    int pick;
    logic [INDEX_W-1:0] a_list [$];
    logic [INDEX_W-1:0] idx;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    n_sent   = 0;
    n_fail   = 0;
    n_first  = 0;
    n_total  = 0;
    b_seen   = 1'b0;
    ovf_held = 1'b0;
    ord_held = 1'b0;
    sender_burst = 1'b0;

    dir_rows.push_back(row_res(MODE_READ,  16'h0000, 32'h0000_0000,
                               res_of(16'h0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0)));
    dir_rows.push_back(row    (MODE_LOAD,  16'h0000, 32'h7FFF_FFFF));
    dir_rows.push_back(row    (MODE_ADD,   16'h0000, 32'h0000_0001));
    dir_rows.push_back(row_res(MODE_READ,  16'hFFFF, 32'hFFFF_FFFF,
                               res_of(16'h0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0)));
    dir_rows.push_back(row    (MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(row    (MODE_LOAD,  16'hFFFF, 32'h8000_0000));
    dir_rows.push_back(row    (MODE_ADD,   16'hFFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(row_res(MODE_READ,  16'h0000, 32'h0000_0000,
                               res_of(16'hFFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0)));
    dir_rows.push_back(row    (MODE_LOAD,  16'h0005, 32'h0000_000A));
    dir_rows.push_back(row_res(MODE_READ,  16'h0000, 32'h0000_0000,
                               res_of(16'hFFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1)));
    dir_rows.push_back(row    (MODE_CLEAR, 16'h0000, 32'h0000_0000));
    dir_rows.push_back(row_res(MODE_READ,  16'h0000, 32'h0000_0000,
                               res_of(16'h0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0)));
    dir_rows.push_back(row    (MODE_LOAD,  16'h0007, 32'h0000_0001));
    dir_rows.push_back(row    (MODE_LOAD,  16'h0007, 32'h0000_0002));
    dir_rows.push_back(row    (MODE_LOAD,  16'h1234, 32'hFFFF_0000));
    dir_rows.push_back(row    (MODE_ADD,   16'h0007, 32'h0001_0000));
    dir_rows.push_back(row    (MODE_ADD,   16'h0009, 32'h0000_0003));
    dir_rows.push_back(row    (MODE_ADD,   16'h0009, 32'h0000_0004));
    dir_rows.push_back(row    (MODE_ADD,   16'h0007, 32'h0000_0005));
    dir_rows.push_back(row    (MODE_ADD,   16'h1234, 32'h0001_0000));
    dir_rows.push_back(row    (MODE_READ,  16'h0000, 32'h0000_0000));
    dir_rows.push_back(row    (MODE_LOAD,  16'h0001, 32'h0000_0001));
    dir_rows.push_back(row    (MODE_READ,  16'hFFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(row    (MODE_CLEAR, 16'h0000, 32'h0000_0000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < dir_rows.size(); k++) begin
      send_item(dir_rows[k].item, dir_rows[k].has_res, dir_rows[k].res);
    end

    while (n_sent < ITEM_TARGET) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_plain(mode_t'($urandom_range(0, 3)), 16'($urandom), rand_value());
        end
      end else begin
        // Skipping the clear now and then stacks an episode on the previous table.
        if ($urandom_range(0, 9) != 0) send_plain(MODE_CLEAR, 16'($urandom), 32'($urandom));
        a_list.delete();
        n_a = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
        for (k = 0; k < n_a; k++) begin
          idx = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
          a_list.push_back(idx);
          send_plain(MODE_LOAD, idx, rand_value());
        end
        n_b = $urandom_range(0, 10);
        for (k = 0; k < n_b; k++) begin
          pick = $urandom_range(0, 9);
          if (pick < 6 && a_list.size() != 0) idx = a_list[$urandom_range(0, a_list.size() - 1)];
          else if (pick < 8) idx = 16'($urandom_range(0, 15));
          else idx = 16'($urandom);
          send_plain(MODE_ADD, idx, rand_value());
          if ($urandom_range(0, 14) == 0) send_plain(MODE_LOAD, 16'($urandom), rand_value());
          if ($urandom_range(0, 19) == 0) send_plain(MODE_READ, 16'($urandom), 32'($urandom));
        end
        send_plain(MODE_READ, 16'($urandom), 32'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result receiver and checker.
  initial begin
    out_item_t exp_entry;
    int gap;
    int n_seen;
    bit quiet;
    bit held;

    out_ready <= 1'b0;
    n_seen = 0;
    quiet  = 1'b0;
    held   = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (n_seen % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 13);
      // One long hold-off lets the output back up into the input channel.
      if (!held && n_seen == HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_seen++;
      if (pending_entries.size() == 0) begin
        n_fail++;
        $display("%0t: result transfer with none expected, got %h", $time, out_data);
      end else begin
        exp_entry = pending_entries.pop_front();
        check_field("index_res",   exp_entry.index_res,   out_data.index_res);
        check_field("value_res",   exp_entry.value_res,   out_data.value_res);
        check_field("last",        exp_entry.last,        out_data.last);
        check_field("empty_res",   exp_entry.empty_res,   out_data.empty_res);
        check_field("overflow",    exp_entry.overflow,    out_data.overflow);
        check_field("order_error", exp_entry.order_error, out_data.order_error);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/svadd_pkg.sv
sv/svadd_ram.sv
sv/svadd_ctrl.sv
sv/svadd_dp.sv
sv/sparse_vector_add_top.sv
tb/testbench.sv
